### rtl/core/prq_pkg.sv
`default_nettype none

package prq_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int ID_WIDTH       = 8;
    localparam int PRIORITY_WIDTH = 4;
    localparam int COUNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_POP     = 2'd1,
        CMD_COMPARE = 2'd2,
        CMD_NONE    = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMP_HEAD_HIGHER = 2'd0,
        CMP_EQUAL       = 2'd1,
        CMP_HEAD_LOWER  = 2'd2,
        CMP_EMPTY       = 2'd3
    } compare_t;

    // One queue slot as seen by its neighbors.
    typedef struct packed {
        logic                      valid;
        logic [PRIORITY_WIDTH-1:0] priority_val;
        logic [ID_WIDTH-1:0]       id;
    } entry_t;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic                      insert;
        logic                      pop;
        logic [PRIORITY_WIDTH-1:0] new_priority;
        logic [ID_WIDTH-1:0]       new_id;
    } cell_ctl_t;

endpackage

`default_nettype wire

### rtl/core/prq_cell.sv
`default_nettype none

module prq_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire prq_pkg::cell_ctl_t ctl,
    input  wire prq_pkg::entry_t    prev_entry,
    input  wire logic               prev_flag,
    input  wire prq_pkg::entry_t    next_entry,
    output prq_pkg::entry_t         entry,
    output logic                    flag
);

    logic                               valid_reg;
    logic                               valid_next;
    logic [prq_pkg::PRIORITY_WIDTH-1:0] priority_reg;
    logic [prq_pkg::PRIORITY_WIDTH-1:0] priority_next;
    logic [prq_pkg::ID_WIDTH-1:0]       id_reg;
    logic [prq_pkg::ID_WIDTH-1:0]       id_next;

    // The new entry belongs in front of this slot when the slot is empty or holds a
    // strictly lower priority; equal priorities stay ahead to keep arrival order.
    assign flag = !valid_reg || (priority_reg < ctl.new_priority);

    always_comb
    begin
        valid_next    = valid_reg;
        priority_next = priority_reg;
        id_next       = id_reg;
        priority if (ctl.insert && flag && !prev_flag)
        begin
            valid_next    = 1'b1;
            priority_next = ctl.new_priority;
            id_next       = ctl.new_id;
        end
        else if (ctl.insert && flag)
        begin
            valid_next    = prev_entry.valid;
            priority_next = prev_entry.priority_val;
            id_next       = prev_entry.id;
        end
        else if (ctl.pop)
        begin
            valid_next    = next_entry.valid;
            priority_next = next_entry.priority_val;
            id_next       = next_entry.id;
        end
        else
        begin
            valid_next    = valid_reg;
            priority_next = priority_reg;
            id_next       = id_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        priority_reg <= priority_next;
        id_reg       <= id_next;
    end

    assign entry.valid        = valid_reg;
    assign entry.priority_val = priority_reg;
    assign entry.id           = id_reg;

endmodule

`default_nettype wire

### rtl/core/priority_ready_queue.sv
`default_nettype none

// Sorted ready queue for a scheduler, built as a row of slot cells.
// Command channel: drive command, process_id and priority_req with start high;
// the transfer happens at a rising edge where start is high and busy is low.
// busy stays low, so a command can be issued in every cycle.
// Insert places the entry behind all entries of greater or equal priority;
// pop returns the head and every cell takes its lower neighbor's entry;
// compare checks the head priority against priority_req.
// Each cell decides locally from its own slot, its neighbors and the broadcast
// command, so the sustained rate is one command per cycle.
// The result appears on status, out_id, out_priority, compare_result and
// occupancy with done high for exactly one cycle, the cycle after the command
// transfer. The receiver cannot stall; a result is taken in that cycle.
// Reset clears every slot's valid bit and the entry count; the queue is usable
// as soon as reset is released.
module priority_ready_queue (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [1:0]                         command,
    input  wire logic [prq_pkg::ID_WIDTH-1:0]       process_id,
    input  wire logic [prq_pkg::PRIORITY_WIDTH-1:0] priority_req,
    output logic                                    done,
    output logic [1:0]                              status,
    output logic [prq_pkg::ID_WIDTH-1:0]            out_id,
    output logic [prq_pkg::PRIORITY_WIDTH-1:0]      out_priority,
    output logic [1:0]                              compare_result,
    output logic [prq_pkg::COUNT_WIDTH-1:0]         occupancy
);

    localparam int DEPTH = prq_pkg::QUEUE_DEPTH;

    prq_pkg::entry_t    entries [DEPTH];
    logic [DEPTH-1:0]   flags;
    logic [DEPTH-1:0]   valid_vec;
    prq_pkg::cell_ctl_t ctl;
    prq_pkg::command_t  cmd;
    prq_pkg::entry_t    empty_entry;
    logic               accept;
    logic               full;
    logic               empty;

    logic [prq_pkg::COUNT_WIDTH-1:0]    count_reg;
    logic [prq_pkg::COUNT_WIDTH-1:0]    count_next;
    logic                               done_reg;
    logic [1:0]                         status_reg;
    logic [1:0]                         status_next;
    logic [prq_pkg::ID_WIDTH-1:0]       out_id_reg;
    logic [prq_pkg::ID_WIDTH-1:0]       out_id_next;
    logic [prq_pkg::PRIORITY_WIDTH-1:0] out_priority_reg;
    logic [prq_pkg::PRIORITY_WIDTH-1:0] out_priority_next;
    logic [1:0]                         compare_reg;
    logic [1:0]                         compare_next;

    assign busy        = 1'b0;
    assign accept      = start && !busy;
    assign cmd         = prq_pkg::command_t'(command);
    assign empty       = !entries[0].valid;
    assign full        = entries[DEPTH-1].valid;
    assign empty_entry = '0;

    assign ctl.insert       = accept && (cmd == prq_pkg::CMD_INSERT) && !full;
    assign ctl.pop          = accept && (cmd == prq_pkg::CMD_POP) && !empty;
    assign ctl.new_priority = priority_req;
    assign ctl.new_id       = process_id;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        prq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .prev_entry ((i == 0) ? empty_entry : entries[(i == 0) ? 0 : i - 1]),
            .prev_flag  ((i == 0) ? 1'b0 : flags[(i == 0) ? 0 : i - 1]),
            .next_entry ((i == DEPTH - 1) ? empty_entry
                                          : entries[(i == DEPTH - 1) ? i : i + 1]),
            .entry      (entries[i]),
            .flag       (flags[i])
        );
        assign valid_vec[i] = entries[i].valid;
    end

    always_comb
    begin
        count_next        = count_reg;
        status_next       = prq_pkg::STATUS_OK;
        out_id_next       = '0;
        out_priority_next = '0;
        compare_next      = prq_pkg::CMP_HEAD_HIGHER;
        unique case (cmd)
            prq_pkg::CMD_INSERT:
            begin
                if (full)
                begin
                    status_next = prq_pkg::STATUS_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            prq_pkg::CMD_POP:
            begin
                if (empty)
                begin
                    status_next = prq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    out_id_next       = entries[0].id;
                    out_priority_next = entries[0].priority_val;
                    count_next        = count_reg - 1'b1;
                end
            end
            prq_pkg::CMD_COMPARE:
            begin
                priority if (empty)
                    compare_next = prq_pkg::CMP_EMPTY;
                else if (entries[0].priority_val > priority_req)
                    compare_next = prq_pkg::CMP_HEAD_HIGHER;
                else if (entries[0].priority_val == priority_req)
                    compare_next = prq_pkg::CMP_EQUAL;
                else
                    compare_next = prq_pkg::CMP_HEAD_LOWER;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg       <= status_next;
            out_id_reg       <= out_id_next;
            out_priority_reg <= out_priority_next;
            compare_reg      <= compare_next;
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign out_id         = out_id_reg;
    assign out_priority   = out_priority_reg;
    assign compare_result = compare_reg;
    assign occupancy      = count_reg;

`ifndef SYNTH
    // The count must track the number of occupied cells.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) == $countones(valid_vec))
        else $error("entry count differs from occupied cells");

    // Occupied cells always form a contiguous run from the head.
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("occupied cells are not contiguous from the head");

    // The first two cells stay in priority order.
    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        entries[1].valid |-> (entries[0].priority_val >= entries[1].priority_val))
        else $error("head cells out of priority order");

    // One result strobe for each transfer, in the cycle after it.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result strobe missing after a transfer");
`endif

endmodule

`default_nettype wire
